/* rtl/core/nos_pkg.sv */
// Package for the nth occurrence substring search block.
// Holds request kinds, status codes, sequencer states and the structs that
// pass between the sequencer and the top level. Depends on nothing.
package nos_pkg;

   localparam int TEXT_DEPTH_DEF    = 1024;
   localparam int PATTERN_DEPTH_DEF = 32;

   localparam int BYTE_W     = 8;
   localparam int START_W    = 16;
   localparam int NTH_W      = 16;
   localparam int POSITION_W = 11;
   localparam int STATUS_W   = 2;

   typedef enum logic [1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_TEXT    = 2'd1,
      FUNC_PATTERN = 2'd2,
      FUNC_SEARCH  = 2'd3
   } nos_func_type;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NTH_ERR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_CHECK,
      S_ADDR,
      S_CMP,
      S_DONE
   } nos_state_type;

   // search launch from the top level
   typedef struct packed {
      logic                      go;
      logic signed [START_W-1:0] start;
      logic [NTH_W-1:0]          nth;
   } nos_cmd_type;

   // finished search from the sequencer
   typedef struct packed {
      logic                  valid;
      logic                  idle;
      logic [POSITION_W-1:0] position;
      logic [STATUS_W-1:0]   status;
   } nos_result_type;

endpackage

/* rtl/core/nos_byte_store.sv */
// Byte-wide single-port-write, single-port-read memory with registered read.
// Used for both the text and the pattern store. No package dependency.
module nos_byte_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/nos_search_seq.sv */
// Search sequencer: walks candidate positions and compares one pattern byte
// per step through a single shared byte comparator. Depends on nos_pkg.
module nos_search_seq
   import nos_pkg::*;
#(
   parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nos_cmd_type          cmd,
   input  logic [$clog2(TEXT_DEPTH+1)-1:0]    text_len,
   input  logic [$clog2(PATTERN_DEPTH+1)-1:0] pat_len,
   input  logic                 overflow,
   input  logic                 res_ack,
   output logic                 rd_en,
   output logic [$clog2(TEXT_DEPTH)-1:0] text_rd_addr,
   output logic [((PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1)-1:0] pat_rd_addr,
   input  logic [BYTE_W-1:0]    text_rd_data,
   input  logic [BYTE_W-1:0]    pat_rd_data,
   output nos_result_type       res
);

   localparam int TW  = $clog2(TEXT_DEPTH);
   localparam int TLW = $clog2(TEXT_DEPTH+1);
   localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int PLW = $clog2(PATTERN_DEPTH+1);
   localparam int CW  = ((TLW > START_W) ? TLW : START_W) + 2;

   nos_state_type state_ff, state_in;
   logic signed [CW-1:0]   cand_ff, cand_in;
   logic signed [CW-1:0]   last_ff, last_in;
   logic                   fwd_ff, fwd_in;
   logic [NTH_W-1:0]       nth_ff, nth_in;
   logic [PLW-1:0]         k_ff, k_in;
   logic signed [START_W-1:0] origin_ff, origin_in;
   logic                   nth_err_ff, nth_err_in;
   logic [POSITION_W-1:0]  pos_ff, pos_in;

   logic signed [CW-1:0] tl_s, pl_s, start_s, beg_a, beg_b, addr_sum, cand_next;
   logic                 cand_ok, byte_eq;

   assign tl_s      = signed'({{(CW-TLW){1'b0}}, text_len});
   assign pl_s      = signed'({{(CW-PLW){1'b0}}, pat_len});
   assign start_s   = CW'(origin_ff);
   assign beg_a     = tl_s + start_s;
   assign beg_b     = tl_s - pl_s;
   assign addr_sum  = cand_ff + signed'({{(CW-PLW){1'b0}}, k_ff});
   assign cand_next = fwd_ff ? (cand_ff + CW'(1)) : (cand_ff - CW'(1));
   assign cand_ok   = fwd_ff ? (cand_ff < last_ff) : (cand_ff >= CW'(0));
   assign byte_eq   = (text_rd_data == pat_rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      last_ff    <= last_in;
      fwd_ff     <= fwd_in;
      nth_ff     <= nth_in;
      k_ff       <= k_in;
      origin_ff  <= origin_in;
      nth_err_ff <= nth_err_in;
      pos_ff     <= pos_in;
   end

   always_comb begin
      state_in   = state_ff;
      cand_in    = cand_ff;
      last_in    = last_ff;
      fwd_in     = fwd_ff;
      nth_in     = nth_ff;
      k_in       = k_ff;
      origin_in  = origin_ff;
      nth_err_in = nth_err_ff;
      pos_in     = pos_ff;
      rd_en      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd.go) begin
               origin_in  = cmd.start;
               nth_in     = cmd.nth;
               nth_err_in = (cmd.nth == '0);
               pos_in     = '0;
               state_in   = S_INIT;
            end
         end
         S_INIT: begin
            fwd_in  = (origin_ff > 0);
            last_in = tl_s - pl_s + CW'(1);
            if (origin_ff > 0) begin
               cand_in = start_s - CW'(1);
            end else begin
               cand_in = (beg_b < beg_a) ? beg_b : beg_a;
            end
            state_in = nth_err_ff ? S_DONE : S_CHECK;
         end
         S_CHECK: begin
            k_in = '0;
            if (!cand_ok) begin
               state_in = S_DONE;
            end else if (pat_len == '0) begin
               // empty pattern hits at every candidate
               if (nth_ff == NTH_W'(1)) begin
                  pos_in   = POSITION_W'(cand_ff + CW'(1));
                  state_in = S_DONE;
               end else begin
                  nth_in  = nth_ff - NTH_W'(1);
                  cand_in = cand_next;
               end
            end else begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            rd_en    = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!byte_eq) begin
               cand_in  = cand_next;
               state_in = S_CHECK;
            end else if (PLW'(k_ff + 1'b1) == pat_len) begin
               if (nth_ff == NTH_W'(1)) begin
                  pos_in   = POSITION_W'(cand_ff + CW'(1));
                  state_in = S_DONE;
               end else begin
                  nth_in   = nth_ff - NTH_W'(1);
                  cand_in  = cand_next;
                  state_in = S_CHECK;
               end
            end else begin
               k_in     = PLW'(k_ff + 1'b1);
               state_in = S_ADDR;
            end
         end
         S_DONE: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign text_rd_addr = addr_sum[TW-1:0];
   assign pat_rd_addr  = k_ff[PAW-1:0];

   always_comb begin
      res.valid    = (state_ff == S_DONE);
      res.idle     = (state_ff == S_IDLE);
      res.position = pos_ff;
      if (nth_err_ff) begin
         res.status = STATUS_NTH_ERR;
      end else if (overflow) begin
         res.status = STATUS_OVERFLOW;
      end else begin
         res.status = STATUS_OK;
      end
   end

endmodule

/* rtl/core/nth_occurrence_substring_search.sv */
// Top level of the nth occurrence substring search block.
// Holds the store lengths, overflow flag and result register; instantiates
// nos_byte_store twice and nos_search_seq. Depends on nos_pkg.
//
//  channel  dir  tdata                                         tuser
//  req_     in   [7:0] data_byte [23:8] start_pos [39:24] occ  [1:0] func
//  rsp_     out  [10:0] position, zero filled to 16            [1:0] status
//
// Clear and append requests give no response. A search steps through an
// init state, then per candidate a check state and, per pattern byte
// compared, an address state and a compare state; the single byte
// comparator and the registered read of the stores set that sequence.
// Input is stalled for the whole search, and a finished search holds until
// the previous response is taken. Reset clears lengths, overflow flag and
// the response valid; the stores need no clearing pass. A waiting response
// does not stall loads.
module nth_occurrence_substring_search
   import nos_pkg::*;
#(
   parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte, start_pos, occurrence
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // position
   output logic [1:0]  rsp_tuser    // status
);

   localparam int TW  = $clog2(TEXT_DEPTH);
   localparam int TLW = $clog2(TEXT_DEPTH+1);
   localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int PLW = $clog2(PATTERN_DEPTH+1);

   nos_func_type   func;
   logic           req_accept, text_full, pat_full, res_ack;
   logic           text_wr, pat_wr, rd_en;
   logic [TLW-1:0] text_len_ff, text_len_in;
   logic [PLW-1:0] pat_len_ff, pat_len_in;
   logic           overflow_ff, overflow_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [POSITION_W-1:0] rsp_pos_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [TW-1:0]  text_rd_addr;
   logic [PAW-1:0] pat_rd_addr;
   logic [BYTE_W-1:0] text_rd_data, pat_rd_data;
   nos_cmd_type    cmd;
   nos_result_type res;

   assign func       = nos_func_type'(req_tuser);
   assign req_tready = res.idle;
   assign req_accept = req_tvalid && req_tready;
   assign text_full  = (text_len_ff == TLW'(TEXT_DEPTH));
   assign pat_full   = (pat_len_ff == PLW'(PATTERN_DEPTH));
   assign text_wr    = req_accept && (func == FUNC_TEXT) && !text_full;
   assign pat_wr     = req_accept && (func == FUNC_PATTERN) && !pat_full;
   assign res_ack    = !rsp_valid_ff || rsp_tready;

   assign cmd.go    = req_accept && (func == FUNC_SEARCH);
   assign cmd.start = signed'(req_tdata[23:8]);
   assign cmd.nth   = req_tdata[39:24];

   always_comb begin
      text_len_in = text_len_ff;
      pat_len_in  = pat_len_ff;
      overflow_in = overflow_ff;
      if (req_accept) begin
         case (func)
            FUNC_CLEAR: begin
               text_len_in = '0;
               pat_len_in  = '0;
               overflow_in = 1'b0;
            end
            FUNC_TEXT: begin
               if (text_full) begin
                  overflow_in = 1'b1;
               end else begin
                  text_len_in = TLW'(text_len_ff + 1'b1);
               end
            end
            FUNC_PATTERN: begin
               if (pat_full) begin
                  overflow_in = 1'b1;
               end else begin
                  pat_len_in = PLW'(pat_len_ff + 1'b1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.valid && res_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_len_ff  <= '0;
         pat_len_ff   <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         text_len_ff  <= text_len_in;
         pat_len_ff   <= pat_len_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response payload until the next search completes
   always_ff @(posedge clock) begin
      if (res.valid && res_ack) begin
         rsp_pos_ff    <= res.position;
         rsp_status_ff <= res.status;
      end
   end

   nos_byte_store #(
      .DEPTH (TEXT_DEPTH),
      .AW    (TW)
   ) u_text_store (
      .clock   (clock),
      .wr_en   (text_wr),
      .wr_addr (text_len_ff[TW-1:0]),
      .wr_data (req_tdata[7:0]),
      .rd_en   (rd_en),
      .rd_addr (text_rd_addr),
      .rd_data (text_rd_data)
   );

   nos_byte_store #(
      .DEPTH (PATTERN_DEPTH),
      .AW    (PAW)
   ) u_pattern_store (
      .clock   (clock),
      .wr_en   (pat_wr),
      .wr_addr (pat_len_ff[PAW-1:0]),
      .wr_data (req_tdata[7:0]),
      .rd_en   (rd_en),
      .rd_addr (pat_rd_addr),
      .rd_data (pat_rd_data)
   );

   nos_search_seq #(
      .TEXT_DEPTH    (TEXT_DEPTH),
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_search_seq (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .text_len     (text_len_ff),
      .pat_len      (pat_len_ff),
      .overflow     (overflow_ff),
      .res_ack      (res_ack),
      .rd_en        (rd_en),
      .text_rd_addr (text_rd_addr),
      .pat_rd_addr  (pat_rd_addr),
      .text_rd_data (text_rd_data),
      .pat_rd_data  (pat_rd_data),
      .res          (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-POSITION_W){1'b0}}, rsp_pos_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_text_len_bound: assert property (@(posedge clock) disable iff (reset)
      text_len_ff <= TLW'(TEXT_DEPTH))
      else $error("text length beyond store depth");

   a_pat_len_bound: assert property (@(posedge clock) disable iff (reset)
      pat_len_ff <= PLW'(PATTERN_DEPTH))
      else $error("pattern length beyond store depth");

   a_full_sets_overflow: assert property (@(posedge clock) disable iff (reset)
      req_accept && (func == FUNC_TEXT) && text_full |=> overflow_ff)
      else $error("append to full text store did not flag overflow");

   a_nth_err_no_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_NTH_ERR) |-> (rsp_pos_ff == '0))
      else $error("occurrence error response carries a position");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.go |=> !req_tready)
      else $error("request taken while a search is running");

endmodule
